/* src/fbsc_pkg.sv */
// ----------------------------------------------------------------------------
// fbsc_pkg
// Shared types and constants of the frustum box/sphere cull core.
// ----------------------------------------------------------------------------
`default_nettype none

package fbsc_pkg;

	// default geometry of the plane store
	localparam int MAX_VIEWS_DEF       = 4;
	localparam int PLANES_PER_VIEW_DEF = 6;
	localparam int FRAC_BITS_DEF       = 16;

	// configuration port
	localparam int CFG_AW             = 3;
	localparam int CFG_DW             = 32;
	localparam int ACTIVE_VIEWS_W     = 3;
	localparam int REG_ACTIVE_VIEWS   = 0;
	localparam logic [ACTIVE_VIEWS_W-1:0] ACTIVE_VIEWS_RST = 3'd1;

	// item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TEST = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	// one stored plane
	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic signed [31:0] off;
	} plane_t;

	// bounding volume under test
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic signed [31:0] rad;
		logic [30:0]        ex;
		logic [30:0]        ey;
		logic [30:0]        ez;
	} vol_t;

	// travels with each plane read through the test pipeline
	typedef struct packed {
		logic valid;
		logic last_plane;
		logic last_all;
	} tag_t;

	// per-plane verdict
	typedef struct packed {
		logic valid;
		logic pass;
		logic last_plane;
		logic last_all;
	} res_t;

endpackage

`default_nettype wire

/* src/fbsc_in_if.sv */
// ----------------------------------------------------------------------------
// fbsc_in_if
// Input channel: plane loads and volume tests.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbsc_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [1:0]         view_index;
	logic [2:0]         plane_index;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] scalar_w;
	logic [30:0]        ext_x;
	logic [30:0]        ext_y;
	logic [30:0]        ext_z;

	modport source (
		output valid, mode, view_index, plane_index,
		output vec_x, vec_y, vec_z, scalar_w, ext_x, ext_y, ext_z,
		input  ready
	);
	modport sink (
		input  valid, mode, view_index, plane_index,
		input  vec_x, vec_y, vec_z, scalar_w, ext_x, ext_y, ext_z,
		output ready
	);
endinterface

`default_nettype wire

/* src/fbsc_out_if.sv */
// ----------------------------------------------------------------------------
// fbsc_out_if
// Output channel: one visibility word per volume test.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbsc_out_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink   (input valid, visible, output ready);
endinterface

`default_nettype wire

/* src/fbsc_plane_ram.sv */
// ----------------------------------------------------------------------------
// fbsc_plane_ram
// Plane store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsc_plane_ram #(
	parameter int DEPTH = fbsc_pkg::MAX_VIEWS_DEF * fbsc_pkg::PLANES_PER_VIEW_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire fbsc_pkg::plane_t wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output fbsc_pkg::plane_t      rdata
);

	fbsc_pkg::plane_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/fbsc_plane_test.sv */
// ----------------------------------------------------------------------------
// fbsc_plane_test
// Plane test pipeline: products, sums, then the sphere and box compares.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsc_plane_test #(
	parameter int FRAC_BITS = fbsc_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fbsc_pkg::tag_t   tag_s1,
	input  wire fbsc_pkg::plane_t plane_s1,
	input  wire fbsc_pkg::vol_t   vol,
	output fbsc_pkg::res_t        res
);

	localparam int PW = 64 - FRAC_BITS;   // truncated signed product
	localparam int QW = 63 - FRAC_BITS;   // truncated extent product
	localparam int SW = 66 - FRAC_BITS;   // sums never overflow at this width

	logic [31:0]        ax, ay, az;
	logic signed [63:0] mx, my, mz;
	logic [62:0]        mqx, mqy, mqz;

	fbsc_pkg::tag_t     tag_s2, tag_s3;
	logic signed [PW-1:0] px_s2, py_s2, pz_s2;
	logic [QW-1:0]        qx_s2, qy_s2, qz_s2;
	logic signed [31:0]   off_s2;
	logic signed [SW-1:0] s_s3, r_s3;

	// |n|, -2^31 maps onto 2^31 as unsigned
	assign ax = plane_s1.nx[31] ? ($unsigned(~plane_s1.nx) + 32'd1) : $unsigned(plane_s1.nx);
	assign ay = plane_s1.ny[31] ? ($unsigned(~plane_s1.ny) + 32'd1) : $unsigned(plane_s1.ny);
	assign az = plane_s1.nz[31] ? ($unsigned(~plane_s1.nz) + 32'd1) : $unsigned(plane_s1.nz);

	assign mx  = plane_s1.nx * vol.cx;
	assign my  = plane_s1.ny * vol.cy;
	assign mz  = plane_s1.nz * vol.cz;
	assign mqx = vol.ex * ax;
	assign mqy = vol.ey * ay;
	assign mqz = vol.ez * az;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// upper bits of the product give the floor of the scaled value
	always_ff @(posedge clk) begin
		px_s2  <= mx[63:FRAC_BITS];
		py_s2  <= my[63:FRAC_BITS];
		pz_s2  <= mz[63:FRAC_BITS];
		qx_s2  <= mqx[62:FRAC_BITS];
		qy_s2  <= mqy[62:FRAC_BITS];
		qz_s2  <= mqz[62:FRAC_BITS];
		off_s2 <= plane_s1.off;
	end

	always_ff @(posedge clk) begin
		s_s3 <= SW'(px_s2) + SW'(py_s2) + SW'(pz_s2) - SW'(off_s2);
		r_s3 <= $signed(SW'(qx_s2) + SW'(qy_s2) + SW'(qz_s2));
	end

	always_comb begin
		res.valid      = tag_s3.valid;
		res.last_plane = tag_s3.last_plane;
		res.last_all   = tag_s3.last_all;
		res.pass       = !(s_s3 > SW'(vol.rad)) && !(s_s3 > r_s3);
	end

endmodule

`default_nettype wire

/* src/frustum_box_sphere_cull_core.sv */
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull_core
// Culls a box/sphere volume against up to MAX_VIEWS stored frustums.
// ----------------------------------------------------------------------------
// Channels: item (valid/ready) carries loads and tests, result (valid/ready)
// carries one visible word per test; a load gives no word.
// A load writes one plane into the plane store if its indices are in range.
// A test walks the store one plane a cycle through a single shared test
// pipeline, N = min(active_views, MAX_VIEWS) * PLANES_PER_VIEW reads, and no
// new item is taken until the test ends; with zero active views it reads no
// planes and reports not visible.
// The finished word waits in an output register, so new loads and tests are
// accepted while the receiver stalls; a second test then holds in its last
// state until the register frees.
// Reset: active_views returns to 1, the pipeline empties, no word is pending.
// Planes are undefined until loaded. active_views is written over the APB
// port (byte address 0) by the user only while idle; the core does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_sphere_cull_core #(
	parameter int MAX_VIEWS       = fbsc_pkg::MAX_VIEWS_DEF,
	parameter int PLANES_PER_VIEW = fbsc_pkg::PLANES_PER_VIEW_DEF,
	parameter int FRAC_BITS       = fbsc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	fbsc_in_if.sink                          item,
	fbsc_out_if.source                       result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fbsc_pkg::CFG_AW-1:0] paddr,
	input  wire logic [fbsc_pkg::CFG_DW-1:0] pwdata,
	output logic [fbsc_pkg::CFG_DW-1:0]      prdata,
	output logic                             pready
);

	localparam int DEPTH = MAX_VIEWS * PLANES_PER_VIEW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
	localparam int PLW   = (PLANES_PER_VIEW > 1) ? $clog2(PLANES_PER_VIEW) : 1;
	localparam int NW    = $clog2(MAX_VIEWS + 1);

	fbsc_pkg::state_t state_q, state_d;

	logic [fbsc_pkg::ACTIVE_VIEWS_W-1:0] active_views_q;
	logic [NW-1:0]   nviews;
	logic            cfg_wr;
	logic            reg_sel;

	logic            take;
	logic            take_load;
	logic            take_test;
	logic            load_ok;
	logic [AW-1:0]   waddr;
	fbsc_pkg::plane_t wplane;

	logic [AW-1:0]   addr_q;
	logic [VW-1:0]   vw_q;
	logic [PLW-1:0]  pl_q;
	logic            rd_en;
	fbsc_pkg::tag_t  tag_issue, tag_s1;
	fbsc_pkg::plane_t plane_s1;
	fbsc_pkg::vol_t  vol_q;
	fbsc_pkg::res_t  res;

	logic            view_ok_q;
	logic            vis_q;
	logic            out_valid_q;
	logic            out_vis_q;
	logic            out_free;

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign reg_sel = (int'(paddr[fbsc_pkg::CFG_AW-1:2]) == fbsc_pkg::REG_ACTIVE_VIEWS);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? fbsc_pkg::CFG_DW'(active_views_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_views_q <= fbsc_pkg::ACTIVE_VIEWS_RST;
		end else if (cfg_wr) begin
			active_views_q <= pwdata[fbsc_pkg::ACTIVE_VIEWS_W-1:0];
		end
	end

	// counts above the store size saturate
	assign nviews = (int'(active_views_q) > MAX_VIEWS) ? NW'(MAX_VIEWS) : NW'(active_views_q);

	// ---------------- intake ----------------
	assign item.ready = (state_q == fbsc_pkg::ST_IDLE);
	assign take       = item.valid && item.ready;
	assign take_load  = take && (item.mode == fbsc_pkg::MODE_LOAD);
	assign take_test  = take && (item.mode == fbsc_pkg::MODE_TEST);
	assign load_ok    = (int'(item.view_index) < MAX_VIEWS) &&
	                    (int'(item.plane_index) < PLANES_PER_VIEW);
	assign waddr      = AW'(int'(item.view_index) * PLANES_PER_VIEW + int'(item.plane_index));
	assign wplane     = '{nx: item.vec_x, ny: item.vec_y, nz: item.vec_z, off: item.scalar_w};

	always_ff @(posedge clk) begin
		if (take_test) begin
			vol_q <= '{cx: item.vec_x, cy: item.vec_y, cz: item.vec_z, rad: item.scalar_w,
			           ex: item.ext_x, ey: item.ext_y, ez: item.ext_z};
		end
	end

	// ---------------- sequencer ----------------
	assign rd_en                = (state_q == fbsc_pkg::ST_RUN);
	assign tag_issue.valid      = rd_en;
	assign tag_issue.last_plane = (int'(pl_q) == PLANES_PER_VIEW - 1);
	assign tag_issue.last_all   = tag_issue.last_plane && (int'(vw_q) == int'(nviews) - 1);
	assign out_free             = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fbsc_pkg::ST_IDLE: begin
				if (take_test) begin
					state_d = (nviews == '0) ? fbsc_pkg::ST_HOLD : fbsc_pkg::ST_RUN;
				end
			end
			fbsc_pkg::ST_RUN: begin
				if (tag_issue.last_all) begin
					state_d = fbsc_pkg::ST_DRAIN;
				end
			end
			fbsc_pkg::ST_DRAIN: begin
				if (res.valid && res.last_all) begin
					state_d = fbsc_pkg::ST_HOLD;
				end
			end
			fbsc_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = fbsc_pkg::ST_IDLE;
				end
			end
			default: state_d = fbsc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			vw_q   <= '0;
			pl_q   <= '0;
		end else if (take_test) begin
			addr_q <= '0;
			vw_q   <= '0;
			pl_q   <= '0;
		end else if (rd_en) begin
			addr_q <= addr_q + AW'(1);
			if (tag_issue.last_plane) begin
				pl_q <= '0;
				vw_q <= vw_q + VW'(1);
			end else begin
				pl_q <= pl_q + PLW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_issue;
		end
	end

	fbsc_plane_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (take_load && load_ok),
		.waddr (waddr),
		.wdata (wplane),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (plane_s1)
	);

	fbsc_plane_test #(
		.FRAC_BITS (FRAC_BITS)
	) u_test (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_s1   (tag_s1),
		.plane_s1 (plane_s1),
		.vol      (vol_q),
		.res      (res)
	);

	// ---------------- verdict ----------------
	// a view passes only if every one of its planes passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_ok_q <= 1'b1;
			vis_q     <= 1'b0;
		end else if (take_test) begin
			view_ok_q <= 1'b1;
			vis_q     <= 1'b0;
		end else if (res.valid) begin
			if (res.last_plane) begin
				view_ok_q <= 1'b1;
				if (view_ok_q && res.pass) begin
					vis_q <= 1'b1;
				end
			end else begin
				view_ok_q <= view_ok_q && res.pass;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == fbsc_pkg::ST_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fbsc_pkg::ST_HOLD && out_free) begin
			out_vis_q <= vis_q;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.visible = out_vis_q;

	// ---------------- checks ----------------
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (int'(addr_q) < DEPTH))
		else $error("plane read beyond store");

	a_res_in_test: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == fbsc_pkg::ST_RUN || state_q == fbsc_pkg::ST_DRAIN))
		else $error("plane verdict outside a test");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !tag_s1.valid)
		else $error("intake open with reads in flight");

	a_word_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == fbsc_pkg::ST_HOLD))
		else $error("result word not from a finished test");

endmodule

`default_nettype wire
